### rtl/file_entry_table_with_block_map_assert.svh
`ifndef FILE_ENTRY_TABLE_WITH_BLOCK_MAP_ASSERT_SVH
`define FILE_ENTRY_TABLE_WITH_BLOCK_MAP_ASSERT_SVH

// same-cycle implication, off during reset
`define FTB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, off during reset
`define FTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, also checked across reset
`define FTB_ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/ftb_pkg.sv
`timescale 1ns / 1ps

package ftb_pkg;

  localparam int ENTRY_COUNT_DEF = 16;

  typedef enum logic [1:0] {
    OP_FORMAT = 2'd0,
    OP_CREATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_BLOCK  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_BSCAN = 2'd2,
    S_FIN   = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] file_id;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] entry_index;
    logic [3:0] block_number;
  } out_beat_t;

  typedef struct packed {
    logic format;
    logic ent_wr;
    logic ent_clr;
    logic blk_set;
    logic blk_clr;
  } store_ctl_t;

endpackage

### rtl/ftb_store.sv
`timescale 1ns / 1ps

module ftb_store #(
  parameter int ENTRY_COUNT = ftb_pkg::ENTRY_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ftb_pkg::store_ctl_t            ctl,
  input  logic [$clog2(ENTRY_COUNT)-1:0] rd_addr,
  input  logic [$clog2(ENTRY_COUNT)-1:0] ent_addr,
  input  logic [15:0]                    ent_id,
  input  logic [$clog2(ENTRY_COUNT)-1:0] ent_blk,
  input  logic [$clog2(ENTRY_COUNT)-1:0] blk_addr,
  output logic [15:0]                    rd_id_r,
  output logic [$clog2(ENTRY_COUNT)-1:0] rd_blk_r,
  output logic                           rd_valid_r,
  output logic                           blk_used
);

  localparam int IW = $clog2(ENTRY_COUNT);
  localparam logic [ENTRY_COUNT-1:0] USED_INIT = {{(ENTRY_COUNT-2){1'b0}}, 2'b11};

  logic [15:0]            id_mem  [ENTRY_COUNT];
  logic [IW-1:0]          blk_mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] valid_r;
  logic [ENTRY_COUNT-1:0] valid_nxt;
  logic [ENTRY_COUNT-1:0] used_r;
  logic [ENTRY_COUNT-1:0] used_nxt;

  always_ff @(posedge clk) begin
    if (ctl.ent_wr) begin
      id_mem[ent_addr]  <= ent_id;
      blk_mem[ent_addr] <= ent_blk;
    end
    rd_id_r    <= id_mem[rd_addr];
    rd_blk_r   <= blk_mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    if (ctl.format) begin
      valid_nxt = '0;
      used_nxt  = USED_INIT;
    end
    if (ctl.ent_wr) begin
      valid_nxt[ent_addr] = 1'b1;
    end
    if (ctl.ent_clr) begin
      valid_nxt[ent_addr] = 1'b0;
    end
    if (ctl.blk_set) begin
      used_nxt[blk_addr] = 1'b1;
    end
    if (ctl.blk_clr) begin
      used_nxt[blk_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= USED_INIT;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
    end
  end

  assign blk_used = used_r[blk_addr];

endmodule

### rtl/ftb_seq.sv
`timescale 1ns / 1ps

module ftb_seq #(
  parameter int ENTRY_COUNT = ftb_pkg::ENTRY_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ftb_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ftb_pkg::out_beat_t             out_data,
  output ftb_pkg::store_ctl_t            ctl,
  output logic [$clog2(ENTRY_COUNT)-1:0] rd_addr,
  output logic [$clog2(ENTRY_COUNT)-1:0] ent_addr,
  output logic [15:0]                    ent_id,
  output logic [$clog2(ENTRY_COUNT)-1:0] ent_blk,
  output logic [$clog2(ENTRY_COUNT)-1:0] blk_addr,
  input  logic [15:0]                    rd_id,
  input  logic [$clog2(ENTRY_COUNT)-1:0] rd_blk,
  input  logic                           rd_valid,
  input  logic                           blk_used
);

  localparam int IW = $clog2(ENTRY_COUNT);
  localparam logic [IW-1:0] LAST = IW'(ENTRY_COUNT - 1);

  ftb_pkg::state_t    state_r, state_nxt;
  ftb_pkg::op_t       op_r, op_nxt;
  ftb_pkg::status_t   status_r, status_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic               more_r, more_nxt;
  logic               pvld_r, pvld_nxt;
  logic [IW-1:0]      pidx_r, pidx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IW-1:0]      free_idx_r, free_idx_nxt;
  logic [IW-1:0]      bcnt_r, bcnt_nxt;
  logic [IW-1:0]      res_idx_r, res_idx_nxt;
  logic [IW-1:0]      res_blk_r, res_blk_nxt;
  logic               out_valid_r, out_valid_nxt;
  ftb_pkg::out_beat_t out_data_r, out_data_nxt;

  logic          accept;
  logic          match;
  logic          free_now;
  logic          have_free;
  logic [IW-1:0] free_idx_eff;
  logic          scan_last;
  logic          can_load;
  logic [IW+3:0] idx_wide;
  logic [IW+3:0] blk_wide;

  assign accept       = (state_r == ftb_pkg::S_IDLE) && in_valid;
  assign match        = pvld_r && rd_valid && (rd_id == id_r);
  assign free_now     = pvld_r && !rd_valid;
  assign have_free    = free_found_r || free_now;
  assign free_idx_eff = free_found_r ? free_idx_r : pidx_r;
  assign scan_last    = pvld_r && (pidx_r == LAST);
  assign can_load     = !out_valid_r || !out_stall;
  assign idx_wide     = {4'b0000, res_idx_r};
  assign blk_wide     = {4'b0000, res_blk_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.operation == ftb_pkg::OP_FORMAT) ? ftb_pkg::S_FIN
                                                                 : ftb_pkg::S_SCAN;
        end
      end
      ftb_pkg::S_SCAN: begin
        if (match) begin
          state_nxt = ftb_pkg::S_FIN;
        end else if (scan_last) begin
          state_nxt = (op_r == ftb_pkg::OP_CREATE && have_free) ? ftb_pkg::S_BSCAN
                                                                : ftb_pkg::S_FIN;
        end
      end
      ftb_pkg::S_BSCAN: begin
        if (!blk_used || bcnt_r == LAST) begin
          state_nxt = ftb_pkg::S_FIN;
        end
      end
      ftb_pkg::S_FIN: begin
        if (can_load) begin
          state_nxt = ftb_pkg::S_IDLE;
        end
      end
      default: state_nxt = ftb_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt         = op_r;
    id_nxt         = id_r;
    status_nxt     = status_r;
    cnt_nxt        = cnt_r;
    more_nxt       = more_r;
    pvld_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    bcnt_nxt       = bcnt_r;
    res_idx_nxt    = res_idx_r;
    res_blk_nxt    = res_blk_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ctl            = '0;
    rd_addr        = cnt_r;
    blk_addr       = (state_r == ftb_pkg::S_BSCAN) ? bcnt_r : res_blk_r;
    case (state_r)
      ftb_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt         = ftb_pkg::op_t'(in_data.operation);
          id_nxt         = in_data.file_id;
          status_nxt     = ftb_pkg::ST_OK;
          res_idx_nxt    = '0;
          res_blk_nxt    = '0;
          cnt_nxt        = '0;
          more_nxt       = 1'b1;
          free_found_nxt = 1'b0;
          bcnt_nxt       = '0;
        end
      end
      ftb_pkg::S_SCAN: begin
        if (more_r) begin
          pvld_nxt = 1'b1;
          pidx_nxt = cnt_r;
          if (cnt_r == LAST) begin
            more_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (free_now && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = pidx_r;
        end
        if (match) begin
          pvld_nxt = 1'b0;
          if (op_r == ftb_pkg::OP_CREATE) begin
            status_nxt = ftb_pkg::ST_EXISTS;
          end else begin
            status_nxt  = ftb_pkg::ST_OK;
            res_idx_nxt = pidx_r;
            res_blk_nxt = rd_blk;
          end
        end else if (scan_last) begin
          if (op_r != ftb_pkg::OP_CREATE) begin
            status_nxt = ftb_pkg::ST_NOT_FOUND;
          end else if (!have_free) begin
            status_nxt = ftb_pkg::ST_FULL;
          end else begin
            free_idx_nxt = free_idx_eff;
          end
        end
      end
      ftb_pkg::S_BSCAN: begin
        if (!blk_used) begin
          status_nxt  = ftb_pkg::ST_OK;
          res_idx_nxt = free_idx_r;
          res_blk_nxt = bcnt_r;
        end else if (bcnt_r == LAST) begin
          status_nxt = ftb_pkg::ST_NO_BLOCK;
        end else begin
          bcnt_nxt = bcnt_r + 1'b1;
        end
      end
      ftb_pkg::S_FIN: begin
        if (can_load) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = status_r;
          out_data_nxt.entry_index  = idx_wide[3:0];
          out_data_nxt.block_number = blk_wide[3:0];
          if (op_r == ftb_pkg::OP_FORMAT) begin
            ctl.format = 1'b1;
          end else if (status_r == ftb_pkg::ST_OK && op_r == ftb_pkg::OP_CREATE) begin
            ctl.ent_wr  = 1'b1;
            ctl.blk_set = 1'b1;
          end else if (status_r == ftb_pkg::ST_OK && op_r == ftb_pkg::OP_DELETE) begin
            ctl.ent_clr = 1'b1;
            ctl.blk_clr = 1'b1;
          end
        end
      end
      default: begin
        pvld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ftb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pvld_r      <= 1'b0;
      more_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pvld_r      <= pvld_nxt;
      more_r      <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    status_r     <= status_nxt;
    cnt_r        <= cnt_nxt;
    pidx_r       <= pidx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    bcnt_r       <= bcnt_nxt;
    res_idx_r    <= res_idx_nxt;
    res_blk_r    <= res_blk_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = (state_r != ftb_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ent_addr  = res_idx_r;
  assign ent_id    = id_r;
  assign ent_blk   = res_blk_r;

endmodule

### rtl/file_entry_table_with_block_map.sv
`timescale 1ns / 1ps

// File entry table with a free-block map. Each input beat carries an operation
// (format, create, delete, lookup) and a 16-bit file id and yields exactly one
// result beat with a status, the entry index and the block number (low 4 bits).
// Ids live in a table with one read port that a sequencer sweeps one entry per
// cycle through one shared id comparator; create then walks the block map one
// block per cycle for the lowest free block. Format skips the scan, and a scan
// ends early on a hit. The input is stalled while an item is in work; a finished
// result sits in an output register, so the next item is taken while it waits.
// At reset the entry valid bits clear and the block map takes its formatted
// state (blocks 0 and 1 used); no clearing pass.
module file_entry_table_with_block_map #(
  parameter int ENTRY_COUNT = ftb_pkg::ENTRY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ftb_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ftb_pkg::out_beat_t out_data
);

  localparam int IW = $clog2(ENTRY_COUNT);

  ftb_pkg::store_ctl_t ctl;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       ent_addr;
  logic [15:0]         ent_id;
  logic [IW-1:0]       ent_blk;
  logic [IW-1:0]       blk_addr;
  logic [15:0]         rd_id;
  logic [IW-1:0]       rd_blk;
  logic                rd_valid;
  logic                blk_used;

  ftb_seq #(
    .ENTRY_COUNT(ENTRY_COUNT)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .ent_addr (ent_addr),
    .ent_id   (ent_id),
    .ent_blk  (ent_blk),
    .blk_addr (blk_addr),
    .rd_id    (rd_id),
    .rd_blk   (rd_blk),
    .rd_valid (rd_valid),
    .blk_used (blk_used)
  );

  ftb_store #(
    .ENTRY_COUNT(ENTRY_COUNT)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .ent_addr  (ent_addr),
    .ent_id    (ent_id),
    .ent_blk   (ent_blk),
    .blk_addr  (blk_addr),
    .rd_id_r   (rd_id),
    .rd_blk_r  (rd_blk),
    .rd_valid_r(rd_valid),
    .blk_used  (blk_used)
  );

endmodule

### rtl/ftb_checker.sv
`timescale 1ns / 1ps

`include "file_entry_table_with_block_map_assert.svh"

module ftb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ftb_pkg::out_beat_t out_data
);

  logic in_beat;
  logic out_err;
  logic out_zero;

  assign in_beat  = in_valid && !in_stall;
  assign out_err  = out_valid && (out_data.status != ftb_pkg::ST_OK);
  assign out_zero = (out_data.entry_index == 4'd0) && (out_data.block_number == 4'd0);

  // busy right after taking a beat
  `FTB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_beat, in_stall)

  // errors report index and block zero
  `FTB_ASSERT_SAME(a_error_zero, clk, rst_n, out_err, out_zero)

  // stalled result beat holds
  `FTB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // nothing pending out of reset
  `FTB_ASSERT_NEXT_ANY(a_reset_quiet, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind file_entry_table_with_block_map ftb_checker u_ftb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int N_ENT       = ftb_pkg::ENTRY_COUNT_DEF;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 2 * N_ENT + 8;
  localparam int POOL_SIZE   = 24;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  ftb_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  ftb_pkg::out_beat_t out_data;

  file_entry_table_with_block_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // shadow copy of the file table and block map
  bit          ent_valid[N_ENT];
  logic [15:0] ent_id[N_ENT];
  logic [3:0]  ent_blk[N_ENT];
  bit          blk_used[N_ENT];

  ftb_pkg::out_beat_t pending_results[$];
  ftb_pkg::out_beat_t want_beat;
  logic [15:0]        id_pool[POOL_SIZE];
  int                 fails = 0;
  int                 idle_cycles = 0;
  int                 rx_hold_left = 0;
  int                 rx_wait = 0;
  bit                 tx_burst = 0;
  bit                 rx_burst = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void fs_format();
    for (int i = 0; i < N_ENT; i++) begin
      ent_valid[i] = 1'b0;
      ent_id[i]    = '0;
      ent_blk[i]   = '0;
      blk_used[i]  = (i < 2);
    end
  endfunction

  function automatic ftb_pkg::out_beat_t fs_apply(ftb_pkg::in_beat_t b);
    ftb_pkg::out_beat_t r;
    int hit;
    int slot;
    int blk;
    r    = '0;
    hit  = -1;
    slot = -1;
    blk  = -1;
    for (int i = 0; i < N_ENT; i++)
      if (hit < 0 && ent_valid[i] && ent_id[i] == b.file_id) hit = i;
    case (ftb_pkg::op_t'(b.operation))
      ftb_pkg::OP_FORMAT: begin
        fs_format();
      end
      ftb_pkg::OP_CREATE: begin
        for (int i = 0; i < N_ENT; i++) begin
          if (slot < 0 && !ent_valid[i]) slot = i;
          if (blk < 0 && !blk_used[i]) blk = i;
        end
        if (hit >= 0) begin
          r.status = ftb_pkg::ST_EXISTS;
        end else if (slot < 0) begin
          r.status = ftb_pkg::ST_FULL;
        end else if (blk < 0) begin
          r.status = ftb_pkg::ST_NO_BLOCK;
        end else begin
          blk_used[blk]   = 1'b1;
          ent_valid[slot] = 1'b1;
          ent_id[slot]    = b.file_id;
          ent_blk[slot]   = 4'(blk);
          r.entry_index   = 4'(slot);
          r.block_number  = 4'(blk);
        end
      end
      ftb_pkg::OP_DELETE: begin
        if (hit < 0) begin
          r.status = ftb_pkg::ST_NOT_FOUND;
        end else begin
          r.entry_index  = 4'(hit);
          r.block_number = ent_blk[hit];
          blk_used[ent_blk[hit]] = 1'b0;
          ent_valid[hit] = 1'b0;
          ent_id[hit]    = '0;
          ent_blk[hit]   = '0;
        end
      end
      default: begin
        if (hit < 0) begin
          r.status = ftb_pkg::ST_NOT_FOUND;
        end else begin
          r.entry_index  = 4'(hit);
          r.block_number = ent_blk[hit];
        end
      end
    endcase
    return r;
  endfunction

  function automatic ftb_pkg::op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return ftb_pkg::OP_FORMAT;
    if (r < 40) return ftb_pkg::OP_CREATE;
    if (r < 65) return ftb_pkg::OP_DELETE;
    return ftb_pkg::OP_LOOKUP;
  endfunction

  // mostly ids from a small pool so that hits and a full block map are common
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic send_beat(ftb_pkg::op_t op, logic [15:0] id);
    ftb_pkg::in_beat_t b;
    int gap;
    b.operation = op;
    b.file_id   = id;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(fs_apply(b));
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_ops();
    send_beat(ftb_pkg::OP_LOOKUP, 16'h0000);
    send_beat(ftb_pkg::OP_DELETE, 16'hFFFF);
    send_beat(ftb_pkg::OP_CREATE, 16'h0000);
    send_beat(ftb_pkg::OP_CREATE, 16'hFFFF);
    send_beat(ftb_pkg::OP_CREATE, 16'h0000);
    send_beat(ftb_pkg::OP_LOOKUP, 16'hFFFF);
    send_beat(ftb_pkg::OP_DELETE, 16'h0000);
    send_beat(ftb_pkg::OP_LOOKUP, 16'h0000);
    send_beat(ftb_pkg::OP_CREATE, 16'h5A5A);
    send_beat(ftb_pkg::OP_FORMAT, 16'hA5A5);
    send_beat(ftb_pkg::OP_LOOKUP, 16'hFFFF);
    wait_results_done();
  endtask

  // 14 free blocks against 16 entries: the block map runs out first
  task automatic test_block_map_full();
    for (int i = 0; i < N_ENT - 1; i++)
      send_beat(ftb_pkg::OP_CREATE, 16'h8100 + 16'(i));
    send_beat(ftb_pkg::OP_CREATE, 16'h8100);
    send_beat(ftb_pkg::OP_DELETE, 16'h8105);
    send_beat(ftb_pkg::OP_CREATE, 16'h7EFA);
    send_beat(ftb_pkg::OP_LOOKUP, 16'h7EFA);
    send_beat(ftb_pkg::OP_FORMAT, 16'h0000);
    wait_results_done();
  endtask

  task automatic test_backpressure();
    tx_burst     = 1'b1;
    rx_hold_left = 400;
    repeat (12) send_beat(pick_op(), pick_id());
    tx_burst = 1'b0;
    wait_results_done();
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 1200; n++) begin
      if (n % 100 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      send_beat(pick_op(), pick_id());
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    wait_results_done();
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
      if (rx_hold_left > 0) begin
        out_stall <= 1'b1;
        rx_hold_left--;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: unexpected beat st=%0d idx=%0d blk=%0d",
                   out_data.status, out_data.entry_index, out_data.block_number);
      end else begin
        want_beat = pending_results.pop_front();
        if (out_data.status !== want_beat.status ||
            out_data.entry_index !== want_beat.entry_index ||
            out_data.block_number !== want_beat.block_number) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: want st=%0d idx=%0d blk=%0d, got st=%0d idx=%0d blk=%0d",
                     want_beat.status, want_beat.entry_index, want_beat.block_number,
                     out_data.status, out_data.entry_index, out_data.block_number);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    fs_format();
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_block_map_full();
    test_backpressure();
    test_random_mix();
    repeat (TAIL_CYCLES) @(posedge clk);
    fails += pending_results.size();
    if (fails == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

### file_entry_table_with_block_map.f
+incdir+rtl
rtl/ftb_pkg.sv
rtl/ftb_store.sv
rtl/ftb_seq.sv
rtl/file_entry_table_with_block_map.sv
rtl/ftb_checker.sv
verif/tb.sv
